### design/kwbt_pkg.sv
// ----------------------------------------------------------------------------
// kwbt_pkg
// Shared types and constants for the keyed write buffer table.
// ----------------------------------------------------------------------------
package kwbt_pkg;

    localparam int CAPACITY_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam int KEY_BITS         = 32;
    localparam int COUNT_OUT_BITS   = 6;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_DRAIN  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_UPDATED     = 3'd0,
        ST_INSERTED    = 3'd1,
        ST_DROPPED     = 3'd2,
        ST_REMOVED     = 3'd3,
        ST_REMOVE_MISS = 3'd4,
        ST_HIT         = 3'd5,
        ST_MISS        = 3'd6
    } status_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic ld_key;
        logic ld_pay;
        logic shift;
    } cell_ctrl_t;

endpackage

### design/kwbt_cell.sv
// ----------------------------------------------------------------------------
// kwbt_cell
// One table slot: holds a key and payload, compares the key against the
// broadcast key, and takes its neighbour's contents when the row shifts.
// ----------------------------------------------------------------------------
module kwbt_cell #(
    parameter int PAYLOAD_BITS = kwbt_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          aclk,
    input  kwbt_pkg::cell_ctrl_t          ctrl,
    input  logic [kwbt_pkg::KEY_BITS-1:0] cmp_key,
    input  logic [kwbt_pkg::KEY_BITS-1:0] wr_key,
    input  logic [PAYLOAD_BITS-1:0]       wr_pay,
    input  logic [kwbt_pkg::KEY_BITS-1:0] nb_key,
    input  logic [PAYLOAD_BITS-1:0]       nb_pay,
    output logic [kwbt_pkg::KEY_BITS-1:0] key_out,
    output logic [PAYLOAD_BITS-1:0]       pay_out,
    output logic                          match
);
    import kwbt_pkg::*;

    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;

    always_comb begin
        key_next = key_reg;
        pay_next = pay_reg;
        if (ctrl.shift) begin
            key_next = nb_key;
            pay_next = nb_pay;
        end else begin
            if (ctrl.ld_key) begin
                key_next = wr_key;
            end
            if (ctrl.ld_pay) begin
                pay_next = wr_pay;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    assign key_out = key_reg;
    assign pay_out = pay_reg;
    assign match   = (key_reg == cmp_key);

endmodule

### design/keyed_write_buffer_table.sv
// ----------------------------------------------------------------------------
// keyed_write_buffer_table
// Densely packed key/payload table built as a row of slot cells.
// ----------------------------------------------------------------------------
// Write, remove and lookup are captured in the idle state and carried out in
// the execute state, where every cell compares its key with the captured key
// at once and the table is updated. A drain instead emits the held entries from
// cell 0, the row shifting one slot towards cell 0 per emitted result.
// A finished result waits in the output register while the next item is
// taken; a further result waits only if that register is still occupied.
// ----------------------------------------------------------------------------
module keyed_write_buffer_table #(
    parameter int CAPACITY     = kwbt_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = kwbt_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_opcode,
    input  logic [kwbt_pkg::KEY_BITS-1:0]       s_key,
    input  logic [PAYLOAD_BITS-1:0]             s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_status,
    output logic [kwbt_pkg::KEY_BITS-1:0]       m_out_key,
    output logic [PAYLOAD_BITS-1:0]             m_out_payload,
    output logic [kwbt_pkg::COUNT_OUT_BITS-1:0] m_entry_count,
    output logic                                m_full_res,
    output logic                                m_last
);
    import kwbt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    op_t                     op_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    logic                    mv_reg, mv_next;
    status_t                 st_reg, st_next;
    logic [KEY_BITS-1:0]     okey_reg, okey_next;
    logic [PAYLOAD_BITS-1:0] opay_reg, opay_next;
    logic [CW-1:0]           ocnt_reg, ocnt_next;
    logic                    olast_reg, olast_next;

    cell_ctrl_t              ctrl [CAPACITY];
    logic [KEY_BITS-1:0]     ckey [CAPACITY];
    logic [PAYLOAD_BITS-1:0] cpay [CAPACITY];
    logic [KEY_BITS-1:0]     nkey [CAPACITY];
    logic [PAYLOAD_BITS-1:0] npay [CAPACITY];
    logic [CAPACITY-1:0]     cmatch, mvec, last_vec, ins_vec;

    logic [KEY_BITS-1:0]     wr_key, last_key;
    logic [PAYLOAD_BITS-1:0] wr_pay, last_pay, sel_pay;
    logic                    hit, out_free;

    // ---- cell row ----
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == CAPACITY - 1) begin : g_end
            assign nkey[i] = '0;
            assign npay[i] = '0;
        end else begin : g_mid
            assign nkey[i] = ckey[i+1];
            assign npay[i] = cpay[i+1];
        end

        assign mvec[i]     = cmatch[i] & (CW'(i) < count_reg);
        assign last_vec[i] = (CW'(i + 1) == count_reg);
        assign ins_vec[i]  = (CW'(i) == count_reg);

        kwbt_cell #(
            .PAYLOAD_BITS(PAYLOAD_BITS)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl[i]),
            .cmp_key (key_reg),
            .wr_key  (wr_key),
            .wr_pay  (wr_pay),
            .nb_key  (nkey[i]),
            .nb_pay  (npay[i]),
            .key_out (ckey[i]),
            .pay_out (cpay[i]),
            .match   (cmatch[i])
        );
    end

    // one-hot selection of the matching and the last slot
    always_comb begin
        sel_pay  = '0;
        last_key = '0;
        last_pay = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_pay  = sel_pay  | (cpay[i] & {PAYLOAD_BITS{mvec[i]}});
            last_key = last_key | (ckey[i] & {KEY_BITS{last_vec[i]}});
            last_pay = last_pay | (cpay[i] & {PAYLOAD_BITS{last_vec[i]}});
        end
    end

    assign hit      = |mvec;
    assign wr_key   = (op_reg == OP_REMOVE) ? last_key : key_reg;
    assign wr_pay   = (op_reg == OP_REMOVE) ? last_pay : pay_reg;
    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    // ---- sequencer ----
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        mv_next    = mv_reg && !m_ready;
        st_next    = st_reg;
        okey_next  = okey_reg;
        opay_next  = opay_reg;
        ocnt_next  = ocnt_reg;
        olast_next = olast_reg;
        for (int i = 0; i < CAPACITY; i++) begin
            ctrl[i] = '0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                    okey_next  = key_reg;
                    opay_next  = '0;
                    olast_next = 1'b1;
                    mv_next    = 1'b1;
                    unique case (op_reg)
                        OP_WRITE: begin
                            if (hit) begin
                                st_next = ST_UPDATED;
                                for (int i = 0; i < CAPACITY; i++) begin
                                    ctrl[i].ld_pay = mvec[i];
                                end
                            end else if (count_reg < CAP_C) begin
                                st_next    = ST_INSERTED;
                                count_next = count_reg + 1'b1;
                                for (int i = 0; i < CAPACITY; i++) begin
                                    ctrl[i].ld_key = ins_vec[i];
                                    ctrl[i].ld_pay = ins_vec[i];
                                end
                            end else begin
                                st_next = ST_DROPPED;
                            end
                        end
                        OP_REMOVE: begin
                            if (hit) begin
                                st_next    = ST_REMOVED;
                                count_next = count_reg - 1'b1;
                                for (int i = 0; i < CAPACITY; i++) begin
                                    ctrl[i].ld_key = mvec[i] & ~last_vec[i];
                                    ctrl[i].ld_pay = mvec[i] & ~last_vec[i];
                                end
                            end else begin
                                st_next = ST_REMOVE_MISS;
                            end
                        end
                        OP_LOOKUP: begin
                            st_next   = hit ? ST_HIT : ST_MISS;
                            opay_next = sel_pay;
                        end
                        OP_DRAIN: begin
                            if (count_reg == '0) begin
                                st_next   = ST_MISS;
                                okey_next = '0;
                            end else begin
                                state_next = S_DRAIN;
                                mv_next    = mv_reg && !m_ready;
                            end
                        end
                        default: ;
                    endcase
                    ocnt_next = count_next;
                    if (op_reg == OP_DRAIN) begin
                        ocnt_next = '0;
                    end
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    st_next    = ST_HIT;
                    okey_next  = ckey[0];
                    opay_next  = cpay[0];
                    ocnt_next  = '0;
                    olast_next = (count_reg == CW'(1));
                    count_next = count_reg - 1'b1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        ctrl[i].shift = 1'b1;
                    end
                    if (count_reg == CW'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= op_t'(s_opcode);
            key_reg <= s_key;
            pay_reg <= s_payload;
        end
        st_reg    <= st_next;
        okey_reg  <= okey_next;
        opay_reg  <= opay_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

    assign m_valid       = mv_reg;
    assign m_status      = st_reg;
    assign m_out_key     = okey_reg;
    assign m_out_payload = opay_reg;
    assign m_entry_count = COUNT_OUT_BITS'(ocnt_reg);
    assign m_full_res    = (ocnt_reg == CAP_C);
    assign m_last        = olast_reg;

    // ---- assertions ----
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("held count above capacity");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_EXEC)
        else $error("accepted item not executed");

    a_unique_key: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EXEC |-> $onehot0(mvec))
        else $error("key held in more than one slot");

    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DRAIN |-> count_reg != '0)
        else $error("drain running on empty table");

endmodule

### test/keyed_write_buffer_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_write_buffer_table_tb
// Self-checking testbench for the keyed write buffer table.
// ----------------------------------------------------------------------------
// A table model in the bench tracks keys, payloads and the held count. Every
// accepted item queues the results it should produce, and a checker process
// compares each result leaving the block against the oldest one queued. The
// run covers single operations, filling to capacity with dropped writes,
// random mixes of operations and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module keyed_write_buffer_table_tb;
    import kwbt_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int CAP          = CAPACITY_DEF;
    localparam int PAY_W        = PAYLOAD_BITS_DEF;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int END_CYCLES   = 2 * CAP + 20;

    typedef struct {
        status_t                   status;
        logic [KEY_BITS-1:0]       key;
        logic [PAY_W-1:0]          payload;
        logic [COUNT_OUT_BITS-1:0] count;
        logic                      full;
        logic                      last;
    } table_result_t;

    logic                      aclk    = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    op_t                       s_opcode  = OP_WRITE;
    logic [KEY_BITS-1:0]       s_key     = '0;
    logic [PAY_W-1:0]          s_payload = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [2:0]                m_status;
    logic [KEY_BITS-1:0]       m_out_key;
    logic [PAY_W-1:0]          m_out_payload;
    logic [COUNT_OUT_BITS-1:0] m_entry_count;
    logic                      m_full_res;
    logic                      m_last;

    // bench copy of the table
    logic [KEY_BITS-1:0] held_key [CAP];
    logic [PAY_W-1:0]    held_pay [CAP];
    int                  held_n;

    table_result_t expected_q [$];

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    bit sink_hold    = 1'b0;

    int fail_count      = 0;
    int results_checked = 0;
    int cycle_count     = 0;
    int dropped_writes  = 0;
    int full_results    = 0;
    int op_count [4]    = '{0, 0, 0, 0};

    keyed_write_buffer_table uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_key         (s_key),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_key     (m_out_key),
        .m_out_payload (m_out_payload),
        .m_entry_count (m_entry_count),
        .m_full_res    (m_full_res),
        .m_last        (m_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int find_held_slot(logic [KEY_BITS-1:0] k);
        for (int i = 0; i < held_n; i++) begin
            if (held_key[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic void queue_result(status_t st, logic [KEY_BITS-1:0] k,
                                         logic [PAY_W-1:0] p, int cnt, bit is_last);
        table_result_t r;
        r.status  = st;
        r.key     = k;
        r.payload = p;
        r.count   = cnt[COUNT_OUT_BITS-1:0];
        r.full    = (cnt == CAP);
        r.last    = is_last;
        expected_q.push_back(r);
    endfunction

    // updates the bench table and queues the results of one item
    function automatic void predict_table_op(op_t op, logic [KEY_BITS-1:0] k,
                                             logic [PAY_W-1:0] p);
        int slot;
        int n;
        slot = find_held_slot(k);
        case (op)
            OP_WRITE: begin
                if (slot >= 0) begin
                    held_pay[slot] = p;
                    queue_result(ST_UPDATED, k, '0, held_n, 1'b1);
                end else if (held_n < CAP) begin
                    held_key[held_n] = k;
                    held_pay[held_n] = p;
                    held_n++;
                    queue_result(ST_INSERTED, k, '0, held_n, 1'b1);
                end else begin
                    dropped_writes++;
                    queue_result(ST_DROPPED, k, '0, held_n, 1'b1);
                end
            end
            OP_REMOVE: begin
                if (slot >= 0) begin
                    held_key[slot] = held_key[held_n-1];
                    held_pay[slot] = held_pay[held_n-1];
                    held_n--;
                    queue_result(ST_REMOVED, k, '0, held_n, 1'b1);
                end else begin
                    queue_result(ST_REMOVE_MISS, k, '0, held_n, 1'b1);
                end
            end
            OP_LOOKUP: begin
                if (slot >= 0) queue_result(ST_HIT, k, held_pay[slot], held_n, 1'b1);
                else queue_result(ST_MISS, k, '0, held_n, 1'b1);
            end
            default: begin
                n = held_n;
                held_n = 0;
                if (n == 0) queue_result(ST_MISS, '0, '0, 0, 1'b1);
                for (int i = 0; i < n; i++) begin
                    queue_result(ST_HIT, held_key[i], held_pay[i], 0, i == n - 1);
                end
            end
        endcase
    endfunction

    task automatic send_item(op_t op, logic [KEY_BITS-1:0] k, logic [PAY_W-1:0] p);
        while (src_idle_en && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_key     <= k;
        s_payload <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        op_count[op]++;
        predict_table_op(op, k, p);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    function automatic void check_table_result();
        table_result_t e;
        if (expected_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("Unexpected result: st=%0d key=%h pay=%h cnt=%0d last=%b",
                         m_status, m_out_key, m_out_payload, m_entry_count, m_last);
            return;
        end
        e = expected_q.pop_front();
        results_checked++;
        if (m_full_res) full_results++;
        if (m_status !== e.status || m_out_key !== e.key || m_out_payload !== e.payload ||
            m_entry_count !== e.count || m_full_res !== e.full || m_last !== e.last) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("Mismatch on result %0d:", results_checked);
                $display("  got st=%0d key=%h pay=%h cnt=%0d full=%b last=%b",
                         m_status, m_out_key, m_out_payload, m_entry_count,
                         m_full_res, m_last);
                $display("  exp st=%0d key=%h pay=%h cnt=%0d full=%b last=%b",
                         e.status, e.key, e.payload, e.count, e.full, e.last);
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_table_result();
        if (sink_hold) m_ready <= 1'b0;
        else if (sink_idle_en) m_ready <= ($urandom_range(99) >= 38);
        else m_ready <= 1'b1;
    end

    function automatic logic [PAY_W-1:0] rand_payload();
        int r;
        r = $urandom_range(19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (held_n != 0 && r < 55) return held_key[$urandom_range(held_n - 1)];
        if (r < 75) return $urandom_range(15);
        return $urandom;
    endfunction

    function automatic logic [KEY_BITS-1:0] fresh_key();
        logic [KEY_BITS-1:0] k;
        do k = $urandom; while (find_held_slot(k) >= 0);
        return k;
    endfunction

    task automatic test_single_ops();
        send_item(OP_DRAIN,  '0, '0);
        send_item(OP_LOOKUP, '0, '1);
        send_item(OP_REMOVE, '1, '0);
        send_item(OP_WRITE,  '0, '0);
        send_item(OP_WRITE,  '1, '1);
        send_item(OP_WRITE,  '0, '1);
        send_item(OP_LOOKUP, '0, '0);
        send_item(OP_LOOKUP, '1, 64'h0123_4567_89ab_cdef);
        send_item(OP_WRITE,  32'h5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send_item(OP_WRITE,  32'haaaa_aaaa, 64'h5555_5555_5555_5555);
        // head removal pulls the tail entry into slot 0
        send_item(OP_REMOVE, '0, '1);
        send_item(OP_LOOKUP, 32'haaaa_aaaa, '0);
        send_item(OP_REMOVE, 32'h5555_5555, '0);
        send_item(OP_REMOVE, 32'h5555_5555, '0);
        send_item(OP_LOOKUP, 32'h5555_5555, '0);
        send_item(OP_DRAIN,  '1, '1);
        send_item(OP_LOOKUP, '1, '0);
        send_item(OP_DRAIN,  32'h1234_5678, '0);
        stop_sending();
        wait_results_drained();
    endtask

    task automatic test_fill_to_capacity();
        for (int pass = 0; pass < 2; pass++) begin
            while (held_n < CAP) send_item(OP_WRITE, fresh_key(), rand_payload());
            send_item(OP_WRITE, fresh_key(), rand_payload());
            send_item(OP_WRITE, held_key[$urandom_range(CAP - 1)], rand_payload());
            send_item(OP_LOOKUP, held_key[CAP-1], '0);
            send_item(OP_REMOVE, held_key[$urandom_range(1, CAP - 2)], '0);
            send_item(OP_WRITE, fresh_key(), rand_payload());
            send_item(OP_WRITE, fresh_key(), rand_payload());
            send_item(OP_REMOVE, held_key[CAP-1], '0);
            send_item(OP_REMOVE, held_key[0], '0);
            send_item(OP_DRAIN, $urandom, rand_payload());
        end
        stop_sending();
        wait_results_drained();
    endtask

    task automatic test_random_mix(int n_items);
        int  r;
        op_t op;
        bit  fill_bias;
        for (int i = 0; i < n_items; i++) begin
            if (i % 50 == 0) begin
                src_idle_en  = (i / 50 != 3);
                sink_idle_en <= (i / 50 != 3);
            end
            fill_bias = ((i / 50) % 2 == 0);
            r = $urandom_range(99);
            if (r < (fill_bias ? 60 : 30)) op = OP_WRITE;
            else if (r < (fill_bias ? 75 : 65)) op = OP_REMOVE;
            else if (r < 96) op = OP_LOOKUP;
            else op = OP_DRAIN;
            send_item(op, pick_key(), rand_payload());
        end
        src_idle_en  = 1'b1;
        sink_idle_en <= 1'b1;
        stop_sending();
        wait_results_drained();
    endtask

    task automatic test_output_backpressure();
        src_idle_en = 1'b0;
        fork
            begin
                sink_hold <= 1'b1;
                for (int c = 0; c < 400; c++) @(posedge aclk);
                sink_hold <= 1'b0;
            end
            begin
                for (int i = 0; i < 24; i++) send_item(OP_WRITE, fresh_key(), rand_payload());
                send_item(OP_DRAIN, '0, '0);
                for (int i = 0; i < 10; i++) send_item(OP_WRITE, pick_key(), rand_payload());
                send_item(OP_LOOKUP, pick_key(), '0);
                send_item(OP_REMOVE, pick_key(), '0);
                send_item(OP_DRAIN, '0, '0);
                stop_sending();
            end
        join
        src_idle_en = 1'b1;
        wait_results_drained();
    endtask

    initial begin
        held_n = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_ops();
        test_fill_to_capacity();
        test_random_mix(260);
        test_output_backpressure();

        repeat (END_CYCLES) @(posedge aclk);
        $display("Sent %0d writes, %0d removes, %0d lookups, %0d drains; %0d results checked",
                 op_count[OP_WRITE], op_count[OP_REMOVE], op_count[OP_LOOKUP],
                 op_count[OP_DRAIN], results_checked);
        $display("%0d writes dropped on a full table, %0d results reported full, %0d failures",
                 dropped_writes, full_results, fail_count);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
